[rtl/ffla_pkg.sv]
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared constants, codes and types of the first-fit free list allocator.
// ----------------------------------------------------------------------------
package ffla_pkg;

	localparam int DEF_ARENA_UNITS    = 65536;
	localparam int DEF_UNIT_BYTES     = 16;
	localparam int DEF_MIN_GROW_UNITS = 1024;

	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_W      = 32;
	localparam int ADDR_W     = 16;
	localparam int STATUS_W   = 3;

	localparam logic [CFG_W-1:0] MAX_REQ_RESET = 32'd500000;

	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_CALLOC   = 2'd1,
		OP_FREE     = 2'd2,
		OP_FREE_ALT = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		RS_OK        = 3'd0,
		RS_ZERO      = 3'd1,
		RS_TOO_LARGE = 3'd2,
		RS_OVERFLOW  = 3'd3,
		RS_NO_MEM    = 3'd4,
		RS_FREE_IGN  = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL,
		S_CHECK,
		S_A_RD,
		S_A_FIRST,
		S_A_EVAL,
		S_A_SPLIT,
		S_F_CHK,
		S_I_RD,
		S_I_WALK,
		S_I_GETBP,
		S_I_GETNX,
		S_I_WRP,
		S_DONE
	} fsm_t;

endpackage

[rtl/ffla_ram.sv]
// ----------------------------------------------------------------------------
// ffla_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffla_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/first_fit_free_list_allocator_core.sv]
// Sequence: refusals are decided in the check state, after the count times size product for
//   calloc or the header read for a free refused on its header; an allocation walks the list
//   from the rover, splitting a larger block, and grows the heap by inserting a new block in
//   address order; a free walks to its place in the list. One request is handled at a time.
// Reset: control registers clear at once, the list holds only the sentinel and the heap is
//   empty; the header RAMs are not cleared, as no header is read before it is written.
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Next-fit block allocator over an arena of header units, with an address-ordered
// circular free list, heap growth and coalescing on free.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core #(
	parameter int ARENA_UNITS    = ffla_pkg::DEF_ARENA_UNITS,
	parameter int UNIT_BYTES     = ffla_pkg::DEF_UNIT_BYTES,
	parameter int MIN_GROW_UNITS = ffla_pkg::DEF_MIN_GROW_UNITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// byte_count [31:0], element_count [63:32], block_address [79:64]
	input  logic [ffla_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode [1:0]
	input  logic [ffla_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status [2:0], payload_address [18:3], zero fill above
	output logic [ffla_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [ffla_pkg::CFG_W-1:0]      cfg_wdata
);

	import ffla_pkg::*;

	// Node codes: arena units 0..ARENA_UNITS-1, the sentinel is ARENA_UNITS.
	localparam int AW    = $clog2(ARENA_UNITS + 1);
	localparam int IW    = $clog2(ARENA_UNITS);
	localparam int KW    = AW + 1;
	localparam int LIMIT = 2 * ARENA_UNITS + 8;
	localparam int SCW   = $clog2(LIMIT + 2);
	localparam int MGW   = $clog2(MIN_GROW_UNITS + 1);
	localparam int GW    = ((AW > MGW) ? AW : MGW) + 1;
	// the unit size is a power of two, so rounding to units is a shift
	localparam int UB_SH = $clog2(UNIT_BYTES);
	localparam int XW    = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W + 1;
	localparam longint BIG_BYTES = longint'(ARENA_UNITS - 1) * longint'(UNIT_BYTES);

	localparam logic [AW-1:0]  SENT       = AW'(ARENA_UNITS);
	localparam logic [SCW-1:0] WALK_LIMIT = SCW'(LIMIT);

	function automatic logic [KW-1:0] key_of(input logic [AW-1:0] n);
		logic [KW-1:0] k;
		k = (n == SENT) ? '0 : ({1'b0, n} + KW'(1));
		return k;
	endfunction

	// ------------------------------------------------------------------ state
	fsm_t state_q, state_d;

	opcode_t     op_q;
	logic [31:0] bytes_q, count_q;
	logic [15:0] baddr_q;
	logic [63:0] prod_s1;

	logic [CFG_W-1:0] max_req_q;
	logic [AW-1:0]    sent_link_q, rover_q, heap_top_q;
	logic             started_q;

	logic [AW-1:0]  nunits_q;

	logic [AW-1:0]  p_q, prevp_q, bp_q, nx_q;
	logic [AW-1:0]  units_p_q, units_bp_q, link_bp_q;
	logic           from_grow_q;
	logic [SCW-1:0] alloc_steps_q, ins_steps_q;
	logic [AW-1:0]  rd_node_q;

	status_t     res_status_q, m_status_q;
	logic [15:0] res_addr_q, m_addr_q;
	logic        m_tvalid_q;

	// --------------------------------------------------------- header memory
	logic          rd_req;
	logic [AW-1:0] rd_node;
	logic [AW-1:0] wr_node, wr_link, wr_units;
	logic          wr_link_en, wr_units_en;
	logic [AW-1:0] link_rdata, units_rdata;
	logic [IW-1:0] ram_raddr, ram_waddr;
	logic          wr_arena;

	assign ram_raddr = (rd_node < SENT) ? rd_node[IW-1:0] : '0;
	assign ram_waddr = wr_node[IW-1:0];
	assign wr_arena  = (wr_node < SENT);

	ffla_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS)) u_link_ram (
		.clk   (clk),
		.we    (wr_link_en && wr_arena),
		.waddr (ram_waddr),
		.wdata (wr_link),
		.raddr (ram_raddr),
		.rdata (link_rdata)
	);

	ffla_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS)) u_units_ram (
		.clk   (clk),
		.we    (wr_units_en && wr_arena),
		.waddr (ram_waddr),
		.wdata (wr_units),
		.raddr (ram_raddr),
		.rdata (units_rdata)
	);

	// Read data of the node addressed last cycle; the sentinel lives in a register
	// and has size zero, codes past it read as a link to the sentinel.
	logic [AW-1:0] link_val, units_val;
	always_comb begin
		if (rd_node_q < SENT) begin
			link_val  = link_rdata;
			units_val = units_rdata;
		end else begin
			link_val  = (rd_node_q == SENT) ? sent_link_q : SENT;
			units_val = '0;
		end
	end

	// ------------------------------------------------------------- datapath
	logic [31:0]    nbytes;
	logic           req_zero, req_ovf, req_big, req_huge;
	logic [32:0]    nbytes_rnd;

	assign nbytes     = (op_q == OP_CALLOC) ? prod_s1[31:0] : bytes_q;
	assign req_zero   = (op_q == OP_CALLOC) ? (count_q == '0 || bytes_q == '0)
	                                        : (bytes_q == '0);
	assign req_ovf    = (prod_s1[63:32] != '0);
	assign req_big    = (nbytes > max_req_q);
	assign req_huge   = ({32'b0, nbytes} > 64'(BIG_BYTES));
	assign nbytes_rnd = {1'b0, nbytes} + 33'(UNIT_BYTES - 1);

	// allocation scan
	logic [AW-1:0] sz_rem;
	logic [AW:0]   split_node;
	logic          fit, fit_exact, split_bad;
	assign fit        = (units_val >= nunits_q);
	assign fit_exact  = (units_val == nunits_q);
	assign sz_rem     = units_val - nunits_q;
	assign split_node = {1'b0, p_q} + {1'b0, sz_rem};
	assign split_bad  = (split_node >= {1'b0, SENT});

	// heap growth
	logic [GW-1:0] grow_nu;
	logic          grow_bad;
	assign grow_nu  = (GW'(nunits_q) < GW'(MIN_GROW_UNITS)) ? GW'(MIN_GROW_UNITS)
	                                                       : GW'(nunits_q);
	assign grow_bad = ((GW'(heap_top_q) + grow_nu) > GW'(ARENA_UNITS));

	// free checks
	logic [XW-1:0] bp_ext;
	logic          free_bad0, free_bad1;
	assign bp_ext    = XW'(baddr_q) - XW'(1);
	assign free_bad0 = (baddr_q == '0) || !started_q || (bp_ext >= XW'(heap_top_q));
	assign free_bad1 = (units_val == '0) ||
	                   (({1'b0, bp_q} + {1'b0, units_val}) > {1'b0, heap_top_q});

	// insertion by address
	logic [KW-1:0] kp, kb, kn_walk, kn_hold;
	logic          ins_brk, merge_n, merge_p;
	assign kp      = key_of(p_q);
	assign kb      = key_of(bp_q);
	assign kn_walk = key_of(link_val);
	assign kn_hold = key_of(nx_q);
	assign ins_brk = (kb > kp && kb < kn_walk) ||
	                 (kp >= kn_walk && (kb > kp || kb < kn_walk));
	assign merge_n = (({1'b0, kb} + (KW+1)'(units_bp_q)) == {1'b0, kn_hold});
	assign merge_p = (({1'b0, kp} + (KW+1)'(units_p_q)) == {1'b0, kb});

	logic          alloc_over, ins_over;
	assign alloc_over = (alloc_steps_q == WALK_LIMIT);
	assign ins_over   = (ins_steps_q == WALK_LIMIT);

	logic [XW-1:0] addr_ext;
	assign addr_ext = XW'(p_q) + XW'(1);

	// ----------------------------------------------------- sequencer control
	logic    fin;
	status_t fin_status;
	logic    fin_addr_en;

	always_comb begin
		state_d     = state_q;
		rd_req      = 1'b0;
		rd_node     = rover_q;
		wr_node     = p_q;
		wr_link     = '0;
		wr_units    = '0;
		wr_link_en  = 1'b0;
		wr_units_en = 1'b0;
		fin         = 1'b0;
		fin_status  = RS_OK;
		fin_addr_en = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = (opcode_t'(s_tuser) == OP_CALLOC) ? S_MUL : S_CHECK;
				end
			end
			S_MUL: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				unique case (op_q)
					OP_ALLOC, OP_CALLOC: begin
						priority if (req_zero) begin
							fin        = 1'b1;
							fin_status = RS_ZERO;
						end else if (op_q == OP_CALLOC && req_ovf) begin
							fin        = 1'b1;
							fin_status = RS_OVERFLOW;
						end else if (req_big) begin
							fin        = 1'b1;
							fin_status = RS_TOO_LARGE;
						end else if (req_huge) begin
							fin        = 1'b1;
							fin_status = RS_NO_MEM;
						end else begin
							state_d = S_A_RD;
						end
					end
					OP_FREE, OP_FREE_ALT: begin
						if (free_bad0) begin
							fin        = 1'b1;
							fin_status = RS_FREE_IGN;
						end else begin
							rd_req  = 1'b1;
							rd_node = AW'(bp_ext);
							state_d = S_F_CHK;
						end
					end
				endcase
			end
			S_A_RD: begin
				rd_req  = 1'b1;
				rd_node = rover_q;
				state_d = S_A_FIRST;
			end
			S_A_FIRST: begin
				rd_req  = 1'b1;
				rd_node = link_val;
				state_d = S_A_EVAL;
			end
			S_A_EVAL: begin
				priority if (fit) begin
					if (fit_exact) begin
						wr_node     = prevp_q;
						wr_link     = link_val;
						wr_link_en  = 1'b1;
						fin         = 1'b1;
						fin_addr_en = 1'b1;
					end else begin
						wr_node     = p_q;
						wr_units    = sz_rem;
						wr_units_en = 1'b1;
						if (split_bad) begin
							fin        = 1'b1;
							fin_status = RS_NO_MEM;
						end else begin
							state_d = S_A_SPLIT;
						end
					end
				end else if (p_q == rover_q) begin
					if (grow_bad) begin
						fin        = 1'b1;
						fin_status = RS_NO_MEM;
					end else begin
						wr_node     = heap_top_q;
						wr_units    = AW'(grow_nu);
						wr_units_en = 1'b1;
						state_d     = S_I_RD;
					end
				end else if (alloc_over) begin
					fin        = 1'b1;
					fin_status = RS_NO_MEM;
				end else begin
					rd_req  = 1'b1;
					rd_node = link_val;
				end
			end
			S_A_SPLIT: begin
				wr_node     = p_q;
				wr_units    = nunits_q;
				wr_units_en = 1'b1;
				fin         = 1'b1;
				fin_addr_en = 1'b1;
			end
			S_F_CHK: begin
				if (free_bad1) begin
					fin        = 1'b1;
					fin_status = RS_FREE_IGN;
				end else begin
					state_d = S_I_RD;
				end
			end
			S_I_RD: begin
				rd_req  = 1'b1;
				rd_node = rover_q;
				state_d = S_I_WALK;
			end
			S_I_WALK: begin
				priority if (ins_brk) begin
					rd_req  = 1'b1;
					rd_node = bp_q;
					state_d = S_I_GETBP;
				end else if (ins_over) begin
					fin        = 1'b1;
					fin_status = from_grow_q ? RS_NO_MEM : RS_FREE_IGN;
				end else begin
					rd_req  = 1'b1;
					rd_node = link_val;
				end
			end
			S_I_GETBP: begin
				rd_req  = 1'b1;
				rd_node = nx_q;
				state_d = S_I_GETNX;
			end
			S_I_GETNX: begin
				wr_node     = bp_q;
				wr_link     = merge_n ? link_val : nx_q;
				wr_link_en  = 1'b1;
				wr_units    = units_bp_q + units_val;
				wr_units_en = merge_n;
				state_d     = S_I_WRP;
			end
			S_I_WRP: begin
				wr_node     = p_q;
				wr_link     = merge_p ? link_bp_q : bp_q;
				wr_link_en  = 1'b1;
				wr_units    = units_p_q + units_bp_q;
				wr_units_en = merge_p;
				if (from_grow_q) begin
					if (alloc_over) begin
						fin        = 1'b1;
						fin_status = RS_NO_MEM;
					end else begin
						state_d = S_A_RD;
					end
				end else begin
					fin = 1'b1;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_DONE;
		end
	end

	// --------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_req_q     <= MAX_REQ_RESET;
			sent_link_q   <= SENT;
			rover_q       <= SENT;
			started_q     <= 1'b0;
			heap_top_q    <= '0;
			m_tvalid_q    <= 1'b0;
			alloc_steps_q <= '0;
			ins_steps_q   <= '0;
			from_grow_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				max_req_q <= cfg_wdata;
			end

			// first allocation opens the list, even when it then runs out
			if (state_q == S_CHECK && (op_q == OP_ALLOC || op_q == OP_CALLOC) &&
			    !req_zero && !(op_q == OP_CALLOC && req_ovf) && !req_big &&
			    !started_q) begin
				started_q   <= 1'b1;
				sent_link_q <= SENT;
				rover_q     <= SENT;
			end

			if (wr_link_en && wr_node == SENT) begin
				sent_link_q <= wr_link;
			end

			// hold the rover where the last scan or insertion stopped
			if ((state_q == S_A_EVAL && fit && fit_exact) || state_q == S_A_SPLIT) begin
				rover_q <= prevp_q;
			end else if (state_q == S_I_WRP) begin
				rover_q <= p_q;
			end

			if (state_q == S_A_EVAL && !fit && p_q == rover_q && !grow_bad) begin
				heap_top_q  <= AW'(GW'(heap_top_q) + grow_nu);
				from_grow_q <= 1'b1;
			end else if (state_q == S_F_CHK) begin
				from_grow_q <= 1'b0;
			end

			if (state_q == S_CHECK) begin
				alloc_steps_q <= '0;
			end else if ((state_q == S_A_EVAL && !fit && p_q != rover_q) ||
			             (state_q == S_I_WRP && from_grow_q)) begin
				alloc_steps_q <= alloc_steps_q + SCW'(1);
			end

			if (state_q == S_I_RD) begin
				ins_steps_q <= '0;
			end else if (state_q == S_I_WALK && !ins_brk) begin
				ins_steps_q <= ins_steps_q + SCW'(1);
			end

			// drop the output once taken, load the next result when free
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q    <= opcode_t'(s_tuser);
			bytes_q <= s_tdata[31:0];
			count_q <= s_tdata[63:32];
			baddr_q <= s_tdata[79:64];
			prod_s1 <= '0;
		end
		if (state_q == S_MUL) begin
			prod_s1 <= {32'b0, count_q} * {32'b0, bytes_q};
		end
		if (state_q == S_CHECK) begin
			// round up to whole units and add the header
			nunits_q <= AW'(nbytes_rnd >> UB_SH) + AW'(1);
			bp_q     <= AW'(bp_ext);
		end
		if (rd_req) begin
			rd_node_q <= rd_node;
		end
		unique case (state_q)
			S_A_RD: begin
				prevp_q <= rover_q;
			end
			S_A_FIRST: begin
				p_q <= link_val;
			end
			S_A_EVAL: begin
				if (fit) begin
					p_q <= split_node[AW-1:0];
				end else if (p_q == rover_q) begin
					bp_q <= heap_top_q;
				end else begin
					prevp_q <= p_q;
					p_q     <= link_val;
				end
			end
			S_I_RD: begin
				p_q <= rover_q;
			end
			S_I_WALK: begin
				if (ins_brk) begin
					nx_q      <= link_val;
					units_p_q <= units_val;
				end else begin
					p_q <= link_val;
				end
			end
			S_I_GETBP: begin
				units_bp_q <= units_val;
			end
			S_I_GETNX: begin
				link_bp_q <= merge_n ? link_val : nx_q;
				if (merge_n) begin
					units_bp_q <= units_bp_q + units_val;
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			res_status_q <= fin_status;
			res_addr_q   <= fin_addr_en ? addr_ext[ADDR_W-1:0] : '0;
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_status_q <= res_status_q;
			m_addr_q   <= res_addr_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - ADDR_W - STATUS_W){1'b0}}, m_addr_q, m_status_q};

`ifndef SYNTHESIS
	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q <= SENT)
		else $error("rover outside arena and sentinel");

	a_heap_range: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q <= SENT)
		else $error("heap top beyond arena");

	a_heap_grows: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q >= $past(heap_top_q))
		else $error("heap top moved down");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_req && (wr_link_en || wr_units_en)))
		else $error("header read and write in the same cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("sequencer idle after an accepted transfer");
`endif

endmodule
